>>> hw/rtl/assert_macros.svh
// assertion macros for the ordered list block
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define OLSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent on one edge, consequent on the next
`define OLSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/olsd_pkg.sv
// shared types and codes for the ordered list block
// no dependencies
package olsd_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned CmdW         = 3;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned CountW       = 5;

  localparam logic [CmdW-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CmdW-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CmdW-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CmdW-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CmdW-1:0] CMD_REMOVE     = 3'd4;
  localparam logic [CmdW-1:0] CMD_CONTAINS   = 3'd5;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;
  localparam logic [StatusW-1:0] ST_MISS  = 2'd3;

  // broadcast from the control to every cell
  typedef struct packed {
    logic              ins_front;
    logic              ins_back;
    logic              drop_front;
    logic              remove;
    logic [ValueW-1:0] value;
  } ctl_t;

endpackage

>>> hw/rtl/olsd_cell.sv
// one list position: holds a value, compares it, shifts with its neighbors
// depends on olsd_pkg
module olsd_cell #(
  parameter int unsigned DEPTH = olsd_pkg::DepthDefault,
  parameter int unsigned INDEX = 0,
  localparam int unsigned LenW = $clog2(DEPTH + 1)
) (
  input  logic                            clk_i,
  input  olsd_pkg::ctl_t                  ctl_i,
  input  logic [LenW-1:0]                 len_i,
  input  logic [olsd_pkg::ValueW-1:0]     left_val_i,
  input  logic [olsd_pkg::ValueW-1:0]     right_val_i,
  input  logic                            hit_prev_i,
  output logic [olsd_pkg::ValueW-1:0]     val_o,
  output logic                            hit_o
);

  logic [olsd_pkg::ValueW-1:0] val_q, val_d;
  logic                        occ;
  logic                        at_back;

  assign occ     = len_i > LenW'(INDEX);
  assign at_back = len_i == LenW'(INDEX);
  assign hit_o   = hit_prev_i | (occ && (val_q == ctl_i.value));
  assign val_o   = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.ins_front) begin
      val_d = left_val_i;
    end else if (ctl_i.ins_back && at_back) begin
      val_d = ctl_i.value;
    end else if (ctl_i.drop_front || (ctl_i.remove && hit_o)) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

>>> hw/rtl/ordered_list_with_search_delete_top.sv
// ordered list of values with deque access, search and delete
// depends on olsd_pkg, olsd_cell and assert_macros.svh
//
// usage:
//   slave channel takes one command item: tuser carries cmd, tdata the value
//   master channel returns one result item per command: found, status, count
//   a row of DEPTH cells holds the list, front in cell 0; every cell compares
//   its value against the command value at once and a hit chain runs through
//   the row to mark the first match, so search, delete, pushes and pops finish
//   in the accept cycle by shifting values, writing the back cell or the count
//   the result item is valid in the cycle after the command is accepted
//   throughput: one item per cycle while the receiver takes results
//   the result register sits between the two sides; when the receiver stalls
//   with a result waiting, tready drops until that result is taken
//   the hit chain through all cells sets the longest path
//   reset empties the list (count zero) and clears the result valid;
//   cell contents are left as they are and never read before written
`include "assert_macros.svh"

module ordered_list_with_search_delete_top #(
  parameter int unsigned DEPTH = olsd_pkg::DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // value[31:0]
  input  logic [2:0]  s_axis_tuser_i,   // cmd[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // found[0], status[2:1], count[7:3]
);

  localparam int unsigned LenW = $clog2(DEPTH + 1);

  logic [LenW-1:0]                len_q, len_d;
  logic                           out_valid_q;
  logic [7:0]                     out_data_q;
  logic                           s_fire;
  logic                           full, empty, found;
  logic [olsd_pkg::CmdW-1:0]      cmd;
  logic [olsd_pkg::StatusW-1:0]   status;
  logic                           res_found;
  logic [31:0]                    len_ext;
  olsd_pkg::ctl_t                 ctl;
  logic [olsd_pkg::ValueW-1:0]    vals [DEPTH];
  logic [DEPTH:0]                 hit;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd             = s_axis_tuser_i;
  assign full            = len_q == LenW'(DEPTH);
  assign empty           = len_q == '0;
  assign found           = hit[DEPTH];

  always_comb begin
    ctl.value      = s_axis_tdata_i;
    ctl.ins_front  = s_fire && (cmd == olsd_pkg::CMD_PUSH_FRONT) && !full;
    ctl.ins_back   = s_fire && (cmd == olsd_pkg::CMD_PUSH_BACK) && !full;
    ctl.drop_front = s_fire && (cmd == olsd_pkg::CMD_POP_FRONT) && !empty;
    ctl.remove     = s_fire && (cmd == olsd_pkg::CMD_REMOVE);
  end

  assign hit[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [olsd_pkg::ValueW-1:0] left_val, right_val;
    if (g == 0) begin : g_first
      assign left_val = s_axis_tdata_i;
    end else begin : g_mid
      assign left_val = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_val = vals[g];
    end else begin : g_inner
      assign right_val = vals[g+1];
    end
    olsd_cell #(
      .DEPTH(DEPTH),
      .INDEX(g)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .len_i      (len_q),
      .left_val_i (left_val),
      .right_val_i(right_val),
      .hit_prev_i (hit[g]),
      .val_o      (vals[g]),
      .hit_o      (hit[g+1])
    );
  end

  always_comb begin
    len_d     = len_q;
    status    = olsd_pkg::ST_OK;
    res_found = 1'b0;
    case (cmd)
      olsd_pkg::CMD_PUSH_BACK, olsd_pkg::CMD_PUSH_FRONT: begin
        if (full) status = olsd_pkg::ST_FULL;
        else      len_d  = len_q + LenW'(1);
      end
      olsd_pkg::CMD_POP_FRONT, olsd_pkg::CMD_POP_BACK: begin
        if (empty) status = olsd_pkg::ST_EMPTY;
        else       len_d  = len_q - LenW'(1);
      end
      olsd_pkg::CMD_REMOVE: begin
        if (found) begin
          len_d     = len_q - LenW'(1);
          res_found = 1'b1;
        end else begin
          status = olsd_pkg::ST_MISS;
        end
      end
      olsd_pkg::CMD_CONTAINS: begin
        if (found) res_found = 1'b1;
        else       status    = olsd_pkg::ST_MISS;
      end
      default: begin
      end
    endcase
  end

  assign len_ext = 32'(len_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        len_q       <= len_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_data_q <= {len_ext[4:0], status, res_found};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `OLSD_ASSERT(a_len_bound, len_q <= LenW'(DEPTH), "list length beyond depth")
  `OLSD_ASSERT_NEXT(a_push_grows,
    s_fire && !full && (cmd == olsd_pkg::CMD_PUSH_BACK || cmd == olsd_pkg::CMD_PUSH_FRONT),
    len_q == $past(len_q) + LenW'(1), "push did not grow the list")
  `OLSD_ASSERT_NEXT(a_result_follows, s_fire, m_axis_tvalid_o, "no result after command")
  `OLSD_ASSERT(a_found_ok, !(m_axis_tvalid_o && m_axis_tdata_o[0]) ||
    (m_axis_tdata_o[2:1] == olsd_pkg::ST_OK), "found with bad status")

endmodule
